### rtl/core/asrp_pkg.sv
// Shared definitions for the ASCII status reply parser core.
// Holds the line-buffer size, the character codes and the scanner phase type.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps

package asrp_pkg;

  localparam int LINE_BUFFER = 24;
  localparam int COUNT_W     = $clog2(LINE_BUFFER);

  // Largest magnitude the accumulator holds; a negative result may reach it.
  localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UP_E  = 8'h45;
  localparam logic [7:0] CH_UP_P  = 8'h50;
  localparam logic [7:0] CH_UP_S  = 8'h53;
  localparam logic [7:0] CH_LO_E  = 8'h65;
  localparam logic [7:0] CH_LO_P  = 8'h70;
  localparam logic [7:0] CH_LO_S  = 8'h73;

  localparam logic REQ_BYTE    = 1'b0;
  localparam logic REQ_TIMEOUT = 1'b1;

  typedef enum logic [5:0] {
    PH_SEEK   = 6'b000001,
    PH_LETTER = 6'b000010,
    PH_SPACE  = 6'b000100,
    PH_DIGITS = 6'b001000,
    PH_DONE   = 6'b010000,
    PH_BAD    = 6'b100000
  } phase_t;

endpackage

### rtl/core/asrp_digit_acc.sv
// Decimal accumulator step for the status reply parser: accum * 10 + digit,
// saturated to the magnitude limit. Depends on asrp_pkg.
`timescale 1ns / 1ps

module asrp_digit_acc (
  input  logic [31:0] accum,
  input  logic [3:0]  digit,
  output logic [31:0] accum_next
);
  import asrp_pkg::*;

  logic [35:0] wide;

  // Times ten as two shifts and an add.
  assign wide = ({4'd0, accum} << 3) + ({4'd0, accum} << 1) + {32'd0, digit};

  assign accum_next = (wide >= {4'd0, MAG_LIMIT}) ? MAG_LIMIT : wide[31:0];

endmodule

### rtl/core/ascii_status_reply_parser_core.sv
// Top level of the ASCII status reply parser: input register, on-the-fly line
// scanner and result register. Depends on asrp_pkg and asrp_digit_acc.
`timescale 1ns / 1ps

// Channel  Dir  Data fields (low bit up)                          User
// s_*      in   rx_byte[7:0], query_is_speed[8], zero pad to 16    req_type
// m_*      out  error_flag, busy_flag, reply_value[31:0],          reply_valid
//               param_echo, zero pad to 40
//
// Each beat is taken into an input register and scanned from there; a line's
// result is written to the output register when the beat that ends it is consumed.
// One beat per cycle is sustained; only a beat that ends a line waits, and
// only while the output register is full and not being taken.
// Synchronous active-high reset clears the line state and both valid flags.

module ascii_status_reply_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // rx_byte[7:0], query_is_speed[8], pad
  input  logic        s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // error_flag, busy_flag, reply_value, param_echo, pad
  output logic        m_tuser    // reply_valid
);
  import asrp_pkg::*;

  // Input register.
  logic       in_valid;
  logic       in_type;
  logic [7:0] in_byte;
  logic       in_speed;

  // Line state.
  logic [COUNT_W-1:0] stored_count, stored_count_next;
  logic               text_ended, text_ended_next;
  phase_t             phase, phase_next;
  logic               flag_error, flag_error_next;
  logic               flag_busy, flag_busy_next;
  logic               number_negative, number_negative_next;
  logic [31:0]        number_accum, number_accum_next;

  // Result register.
  logic        out_valid;
  logic        out_ok;
  logic        out_error;
  logic        out_busy;
  logic [31:0] out_value;
  logic        out_echo;

  logic        ends_line;
  logic        advance;
  logic        is_digit;
  logic [31:0] digit_accum;
  logic        res_ok;
  logic [31:0] res_value;

  assign ends_line = (in_type == REQ_TIMEOUT) || (in_byte == CH_LF);
  assign advance   = in_valid && (!ends_line || !out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign is_digit  = (in_byte inside {[CH_0:CH_9]});

  asrp_digit_acc u_digit_acc (
    .accum      (number_accum),
    .digit      (in_byte[3:0]),
    .accum_next (digit_accum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_type  <= s_tuser;
      in_byte  <= s_tdata[7:0];
      in_speed <= s_tdata[8];
    end
  end

  // Character scanner and line bookkeeping.
  always_comb begin
    stored_count_next    = stored_count;
    text_ended_next      = text_ended;
    phase_next           = phase;
    flag_error_next      = flag_error;
    flag_busy_next       = flag_busy;
    number_negative_next = number_negative;
    number_accum_next    = number_accum;

    if (ends_line) begin
      stored_count_next    = '0;
      text_ended_next      = 1'b0;
      phase_next           = PH_SEEK;
      flag_error_next      = 1'b0;
      flag_busy_next       = 1'b0;
      number_negative_next = 1'b0;
      number_accum_next    = '0;
    end else if (in_byte != CH_CR &&
                 stored_count < COUNT_W'(LINE_BUFFER - 1)) begin
      stored_count_next = stored_count + COUNT_W'(1);
      if (!text_ended) begin
        if (in_byte == CH_NUL) begin
          text_ended_next = 1'b1;
        end else begin
          case (phase)
            PH_SEEK: begin
              if (in_byte == CH_COMMA) phase_next = PH_LETTER;
            end
            PH_LETTER: begin
              phase_next = PH_SPACE;
              if (in_byte == CH_UP_E) begin
                flag_error_next = 1'b1;
                flag_busy_next  = 1'b0;
              end else if (in_byte == CH_LO_E) begin
                flag_error_next = 1'b1;
                flag_busy_next  = 1'b1;
              end else if (in_byte inside {CH_LO_P, CH_LO_S}) begin
                flag_error_next = 1'b0;
                flag_busy_next  = 1'b1;
              end else if (in_byte inside {CH_UP_P, CH_UP_S}) begin
                flag_error_next = 1'b0;
                flag_busy_next  = 1'b0;
              end else begin
                phase_next = PH_BAD;
              end
            end
            PH_SPACE: begin
              if (in_byte inside {CH_SPACE, CH_TAB, CH_VT, CH_FF}) begin
                phase_next = PH_SPACE;
              end else if (in_byte == CH_MINUS) begin
                number_negative_next = 1'b1;
                phase_next           = PH_DIGITS;
              end else if (in_byte == CH_PLUS) begin
                phase_next = PH_DIGITS;
              end else if (is_digit) begin
                number_accum_next = digit_accum;
                phase_next        = PH_DIGITS;
              end else begin
                phase_next = PH_DONE;
              end
            end
            PH_DIGITS: begin
              if (is_digit) number_accum_next = digit_accum;
              else phase_next = PH_DONE;
            end
            default: begin
              phase_next = phase;
            end
          endcase
        end
      end
    end
  end

  assign res_ok = (phase == PH_SPACE) || (phase == PH_DIGITS) || (phase == PH_DONE);

  always_comb begin
    if (!res_ok) begin
      res_value = '0;
    end else if (number_negative) begin
      res_value = 32'd0 - number_accum;
    end else if (number_accum >= MAG_LIMIT) begin
      res_value = MAG_LIMIT - 32'd1;
    end else begin
      res_value = number_accum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count    <= '0;
      text_ended      <= 1'b0;
      phase           <= PH_SEEK;
      flag_error      <= 1'b0;
      flag_busy       <= 1'b0;
      number_negative <= 1'b0;
      number_accum    <= '0;
    end else if (advance) begin
      stored_count    <= stored_count_next;
      text_ended      <= text_ended_next;
      phase           <= phase_next;
      flag_error      <= flag_error_next;
      flag_busy       <= flag_busy_next;
      number_negative <= number_negative_next;
      number_accum    <= number_accum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && ends_line) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && ends_line) begin
      out_ok    <= res_ok;
      out_error <= res_ok && flag_error;
      out_busy  <= res_ok && flag_busy;
      out_value <= res_value;
      out_echo  <= in_speed;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_ok;
  assign m_tdata  = {5'd0, out_echo, out_value, out_busy, out_error};

endmodule
